/* hw/rtl/plg_pkg.sv */
// playback lifecycle guard: shared types, state codes and the transition table
// used by plg_rules and playback_lifecycle_guard_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package plg_pkg;

    localparam int STATE_BITS = 5;
    localparam int NUM_STATES = 25;

    typedef logic [STATE_BITS-1:0] t_state;
    typedef logic [NUM_STATES-1:0] t_state_mask;

    localparam t_state S_NOTCREATED     = 5'd0;
    localparam t_state S_CREATED        = 5'd1;
    localparam t_state S_BUILDING       = 5'd2;
    localparam t_state S_BUILDFAILED    = 5'd3;
    localparam t_state S_READY          = 5'd4;
    localparam t_state S_STARTING       = 5'd5;
    localparam t_state S_BUFFERING      = 5'd6;
    localparam t_state S_PLAYING        = 5'd7;
    localparam t_state S_REBUFFERING    = 5'd8;
    localparam t_state S_STALLED        = 5'd9;
    localparam t_state S_PAUSING        = 5'd10;
    localparam t_state S_PAUSED         = 5'd11;
    localparam t_state S_RESUMING       = 5'd12;
    localparam t_state S_SEEKING        = 5'd13;
    localparam t_state S_FLUSHING       = 5'd14;
    localparam t_state S_TRACKSWITCHING = 5'd15;
    localparam t_state S_DRAINING       = 5'd16;
    localparam t_state S_EOS            = 5'd17;
    localparam t_state S_SYSSUSPENDING  = 5'd18;
    localparam t_state S_SYSSUSPENDED   = 5'd19;
    localparam t_state S_SYSRESUMING    = 5'd20;
    localparam t_state S_RECOVERING     = 5'd21;
    localparam t_state S_FAILED         = 5'd22;
    localparam t_state S_CLOSING        = 5'd23;
    localparam t_state S_CLOSED         = 5'd24;
    localparam t_state S_LAST           = S_CLOSED;

    localparam logic OP_MOVE          = 1'b0;
    localparam logic OP_BUILD_FAILURE = 1'b1;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_CLOSED  = 2'd2;

    typedef struct packed {
        logic       take;
        t_state     to_state;
        logic [1:0] err;
        logic       load_kind;
        logic       clr_kind;
    } t_decision;

    function automatic t_state_mask bit_of(input t_state s);
        bit_of = t_state_mask'(1) << s;
    endfunction

    // ordinary targets per source; closing and closed are handled apart
    function automatic t_state_mask legal_next(input t_state cur);
        t_state_mask m;
        m = '0;
        case (cur)
            S_NOTCREATED:     m = bit_of(S_CREATED) | bit_of(S_BUILDING);
            S_CREATED:        m = bit_of(S_BUILDING);
            S_BUILDING:       m = bit_of(S_READY) | bit_of(S_BUILDFAILED);
            S_BUILDFAILED:    m = bit_of(S_BUILDING);
            S_READY:          m = bit_of(S_STARTING) | bit_of(S_SEEKING)
                                | bit_of(S_TRACKSWITCHING);
            S_STARTING:       m = bit_of(S_PLAYING) | bit_of(S_BUFFERING)
                                | bit_of(S_PAUSING);
            S_BUFFERING:      m = bit_of(S_PLAYING) | bit_of(S_REBUFFERING)
                                | bit_of(S_STALLED) | bit_of(S_PAUSING);
            S_PLAYING:        m = bit_of(S_PAUSING) | bit_of(S_SEEKING)
                                | bit_of(S_TRACKSWITCHING) | bit_of(S_DRAINING)
                                | bit_of(S_REBUFFERING);
            S_REBUFFERING:    m = bit_of(S_PLAYING) | bit_of(S_STALLED)
                                | bit_of(S_PAUSING);
            S_STALLED:        m = bit_of(S_RECOVERING) | bit_of(S_FAILED)
                                | bit_of(S_PAUSING);
            S_PAUSING:        m = bit_of(S_PAUSED);
            S_PAUSED:         m = bit_of(S_RESUMING) | bit_of(S_SEEKING)
                                | bit_of(S_TRACKSWITCHING);
            S_RESUMING:       m = bit_of(S_PLAYING) | bit_of(S_BUFFERING);
            S_SEEKING:        m = bit_of(S_FLUSHING) | bit_of(S_READY)
                                | bit_of(S_PLAYING) | bit_of(S_PAUSED);
            S_FLUSHING:       m = bit_of(S_READY) | bit_of(S_PLAYING) | bit_of(S_PAUSED);
            S_TRACKSWITCHING: m = bit_of(S_READY) | bit_of(S_PLAYING) | bit_of(S_PAUSED);
            S_DRAINING:       m = bit_of(S_EOS);
            S_EOS:            m = bit_of(S_STARTING) | bit_of(S_SEEKING);
            S_SYSSUSPENDING:  m = bit_of(S_SYSSUSPENDED);
            S_SYSSUSPENDED:   m = bit_of(S_SYSRESUMING);
            S_SYSRESUMING:    m = bit_of(S_READY) | bit_of(S_PLAYING) | bit_of(S_PAUSED);
            S_RECOVERING:     m = bit_of(S_READY) | bit_of(S_PLAYING) | bit_of(S_FAILED);
            S_FAILED:         m = bit_of(S_RECOVERING);
            default:          m = '0;
        endcase
        legal_next = m;
    endfunction

    function automatic logic move_legal(input t_state cur, input t_state tgt);
        logic ok;
        t_state_mask m;
        m = legal_next(cur);
        if (cur == S_CLOSED) begin
            ok = (tgt == S_CLOSED);
        end else if (tgt == S_CLOSED) begin
            ok = (cur == S_CLOSING);
        end else if (tgt == S_CLOSING) begin
            ok = 1'b1;
        end else if (cur == S_CLOSING) begin
            ok = 1'b0;
        end else if (cur > S_LAST || tgt > S_LAST) begin
            ok = 1'b0;
        end else begin
            ok = m[tgt];
        end
        move_legal = ok;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/plg_rules.sv */
// playback lifecycle guard: decides one request against the held state
// depends on plg_pkg
`timescale 1ns / 1ps
`default_nettype none

module plg_rules #(
    parameter int KIND_BITS = 4
) (
    input  wire logic                 i_opcode,
    input  wire plg_pkg::t_state      i_target,
    input  wire logic [KIND_BITS-1:0] i_kind,
    input  wire plg_pkg::t_state      i_cur_state,
    output plg_pkg::t_decision        o_dec
);

    always_comb begin
        o_dec = '0;
        if (i_opcode == plg_pkg::OP_MOVE) begin
            if (plg_pkg::move_legal(i_cur_state, i_target)) begin
                o_dec.take     = 1'b1;
                o_dec.to_state = i_target;
                o_dec.err      = plg_pkg::ERR_NONE;
                o_dec.clr_kind = (i_target != plg_pkg::S_BUILDING)
                              && (i_target != plg_pkg::S_BUILDFAILED);
            end else begin
                o_dec.to_state = i_target;
                o_dec.err      = (i_target == plg_pkg::S_CLOSED) ?
                                 plg_pkg::ERR_CLOSED : plg_pkg::ERR_INVALID;
            end
        end else begin
            o_dec.to_state = plg_pkg::S_BUILDFAILED;
            if (i_cur_state == plg_pkg::S_BUILDING && i_kind != '0) begin
                o_dec.take      = 1'b1;
                o_dec.err       = plg_pkg::ERR_NONE;
                o_dec.load_kind = 1'b1;
            end else begin
                o_dec.err = plg_pkg::ERR_INVALID;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/playback_lifecycle_guard_core.sv */
// playback lifecycle guard top level: input register, rule check, result register
// depends on plg_pkg and plg_rules
//
// usage: requests arrive on the s_axis channel, one per beat; tuser carries the
// opcode (move or build failure), tdata the target state and the failure kind.
// each request gives exactly one result beat on m_axis with the accept flag,
// the state before and after, the error code, the stored kind and the revision.
// path: an accepted request waits in the input register, is checked against the
// held state and is then loaded into the result register that drives m_axis.
// throughput: one request per cycle while m_axis_tready is high; the state, kind
// and revision registers are updated in the same cycle the request leaves the input
// register, so the next request sees them immediately.
// stall: when m_axis_tready is low the result register holds, the input
// register fills behind it and s_axis_tready drops; nothing is dropped.
// reset: synchronous, active low; the lifecycle returns to not created, kind
// and revision to zero, and both register stages empty.
`timescale 1ns / 1ps
`default_nettype none

module playback_lifecycle_guard_core #(
    parameter int REVISION_BITS = 32,
    parameter int KIND_BITS     = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,

    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // target_state, failure_kind
    input  wire logic [((plg_pkg::STATE_BITS+KIND_BITS+7)/8)*8-1:0] s_axis_tdata,
    // opcode
    input  wire logic [0:0] s_axis_tuser,

    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // accepted, from_state, to_state, error_code, kind_now, revision
    output logic [((1+2*plg_pkg::STATE_BITS+2+KIND_BITS+REVISION_BITS+7)/8)*8-1:0]
                      m_axis_tdata
);

    localparam int SB      = plg_pkg::STATE_BITS;
    localparam int OUT_W   = 1 + 2*SB + 2 + KIND_BITS + REVISION_BITS;
    localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;

    logic                     r_in_valid;
    logic                     r_in_op;
    plg_pkg::t_state          r_in_tgt;
    logic [KIND_BITS-1:0]     r_in_kind;

    plg_pkg::t_state          r_state;
    logic [KIND_BITS-1:0]     r_kind;
    logic [REVISION_BITS-1:0] r_rev;

    logic                     r_out_valid;
    logic                     r_out_acc;
    plg_pkg::t_state          r_out_from;
    plg_pkg::t_state          r_out_to;
    logic [1:0]               r_out_err;
    logic [KIND_BITS-1:0]     r_out_kind;
    logic [REVISION_BITS-1:0] r_out_rev;

    plg_pkg::t_decision       w_dec;
    logic                     w_adv;
    logic                     w_in_acc;
    plg_pkg::t_state          n_state;
    logic [KIND_BITS-1:0]     n_kind;
    logic [REVISION_BITS-1:0] n_rev;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    plg_rules #(
        .KIND_BITS (KIND_BITS)
    ) u_rules (
        .i_opcode    (r_in_op),
        .i_target    (r_in_tgt),
        .i_kind      (r_in_kind),
        .i_cur_state (r_state),
        .o_dec       (w_dec)
    );

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_rev   = r_rev;
        if (w_dec.take) begin
            n_state = w_dec.to_state;
            n_rev   = r_rev + REVISION_BITS'(1);
            if (w_dec.load_kind) begin
                n_kind = r_in_kind;
            end else if (w_dec.clr_kind) begin
                n_kind = '0;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_op   <= s_axis_tuser[0];
            r_in_tgt  <= s_axis_tdata[SB-1:0];
            r_in_kind <= s_axis_tdata[SB+KIND_BITS-1:SB];
        end
    end

    // lifecycle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plg_pkg::S_NOTCREATED;
            r_kind  <= '0;
            r_rev   <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_rev   <= n_rev;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_acc  <= w_dec.take;
            r_out_from <= r_state;
            r_out_to   <= w_dec.to_state;
            r_out_err  <= w_dec.err;
            r_out_kind <= n_kind;
            r_out_rev  <= n_rev;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_PAD-OUT_W){1'b0}}, r_out_rev, r_out_kind, r_out_err,
                            r_out_to, r_out_from, r_out_acc};

    a_state_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= plg_pkg::S_LAST)
        else $error("lifecycle state out of range");

    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plg_pkg::S_CLOSED) |=> (r_state == plg_pkg::S_CLOSED))
        else $error("left closed state");

    a_rev_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_dec.take) |=> (r_rev == $past(r_rev) + REVISION_BITS'(1)))
        else $error("revision not bumped on taken request");

    a_err_matches_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_acc == (r_out_err == plg_pkg::ERR_NONE)))
        else $error("error code disagrees with accept flag");

endmodule

`default_nettype wire
